// File: sv/dbos_pkg.sv
// Shared types and constants for the descriptor byte order swapper.
// No dependencies; the front end, back end, top and testbench import this package.
`timescale 1ns / 1ps

package dbos_pkg;

   localparam int NUM_DESC_REGS = 6;
   localparam int DESC_W        = 16;
   localparam int BYTE_W        = 8;
   localparam int TOTAL_W       = 20;
   localparam int DCOUNT_W      = 3;
   localparam int DIDX_W        = 3;
   localparam int ADDR_W        = 5;
   localparam int DATA_W        = 32;
   localparam int CODE_W        = 2;
   localparam int UNITS_FIELD_W = 14;
   localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

   // Register map, one 32-bit word per register
   typedef enum logic [2:0] {
      REG_DESC_COUNT  = 3'd0,
      REG_UNIT_DESC_0 = 3'd1,
      REG_UNIT_DESC_1 = 3'd2,
      REG_UNIT_DESC_2 = 3'd3,
      REG_UNIT_DESC_3 = 3'd4,
      REG_UNIT_DESC_4 = 3'd5,
      REG_UNIT_DESC_5 = 3'd6
   } reg_index_type;

   typedef struct packed {
      logic [DCOUNT_W-1:0]                  descriptor_count;
      logic [NUM_DESC_REGS-1:0][DESC_W-1:0] unit_desc;
   } cfg_type;

   // Per-unit status carried beside the gathered bytes
   typedef struct packed {
      logic               done;
      logic [TOTAL_W-1:0] total;
   } unit_meta_type;

endpackage

// File: sv/dbos_fifo.sv
// Short unit queue between the gathering front end and the emitting back end.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps

module dbos_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic             full,
   output logic             head_valid,
   output logic [WIDTH-1:0] head_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign full       = (count_ff == FULL_CNT);
   assign head_valid = (count_ff != '0);
   assign head_data  = mem_ff[rd_ptr_ff];

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("unit queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("unit queue read while empty");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("unit queue count out of range");

endmodule

// File: sv/dbos_front.sv
// Front end: walks the descriptor list, gathers unit bytes, queues units or lone bytes.
// Depends on dbos_pkg.
`timescale 1ns / 1ps

module dbos_front
   import dbos_pkg::*;
#(
   parameter int MAX_DESCRIPTORS = 6,
   parameter int MAX_UNIT_BYTES  = 8,
   parameter int COUNT_BITS      = 14
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  cfg_type                                cfg,
   input  logic                                   accept,
   input  logic [BYTE_W-1:0]                      in_byte,
   input  logic                                   restart,
   output logic                                   push,
   output logic [MAX_UNIT_BYTES-1:0][BYTE_W-1:0]  push_bytes,
   output logic [$clog2(MAX_UNIT_BYTES+1)-1:0]    push_have,
   output unit_meta_type                          push_meta
);

   localparam int HAVE_W = $clog2(MAX_UNIT_BYTES + 1);
   localparam int POS_W  = $clog2(MAX_UNIT_BYTES);
   localparam int UNIT_W = (COUNT_BITS < UNITS_FIELD_W) ? COUNT_BITS : UNITS_FIELD_W;
   localparam logic [DCOUNT_W-1:0] MAX_DESC_C = DCOUNT_W'(MAX_DESCRIPTORS);

   typedef struct packed {
      logic              found;
      logic [DIDX_W-1:0] idx;
   } find_type;

   logic [DIDX_W-1:0]             desc_index_ff, desc_index_in;
   logic [UNIT_W-1:0]             units_left_ff, units_left_in;
   logic [POS_W-1:0]              byte_pos_ff,   byte_pos_in;
   logic [TOTAL_W-1:0]            byte_total_ff, byte_total_in;
   logic [MAX_UNIT_BYTES-1:0][BYTE_W-1:0] unit_buffer_ff;
   logic [NUM_DESC_REGS-1:0]      has_units;
   logic [DCOUNT_W-1:0]           used;

   // First descriptor at or after start that has units
   function automatic find_type find_from(input logic [DIDX_W:0] start,
                                          input logic [NUM_DESC_REGS-1:0] nz);
      find_type r;
      r = '0;
      for (int i = NUM_DESC_REGS - 1; i >= 0; i--) begin
         if (nz[i] && ((DIDX_W+1)'(i) >= start)) begin
            r.found = 1'b1;
            r.idx   = DIDX_W'(i);
         end
      end
      return r;
   endfunction

   function automatic logic [HAVE_W-1:0] unit_size(input cfg_type c,
                                                  input logic [DIDX_W-1:0] idx);
      int sz;
      sz = 1;
      if (int'(idx) < NUM_DESC_REGS) begin
         sz = 1 << c.unit_desc[idx][CODE_W-1:0];
      end
      if (sz > MAX_UNIT_BYTES) begin
         sz = MAX_UNIT_BYTES;
      end
      return HAVE_W'(sz);
   endfunction

   assign used = (cfg.descriptor_count > MAX_DESC_C) ? MAX_DESC_C : cfg.descriptor_count;

   always_comb begin
      for (int i = 0; i < NUM_DESC_REGS; i++) begin
         has_units[i] = (DCOUNT_W'(i) < used) &&
                        (cfg.unit_desc[i][CODE_W +: UNIT_W] != '0);
      end
   end

   always_comb begin
      logic [DIDX_W-1:0]  di;
      logic [UNIT_W-1:0]  ul;
      logic [POS_W-1:0]   bp;
      logic [TOTAL_W-1:0] bt;
      logic [HAVE_W-1:0]  have;
      logic [TOTAL_W:0]   sum;
      logic [DIDX_W:0]    next_start;
      find_type           f_cur;
      find_type           f_first;
      find_type           f_next;
      logic               pass;

      // Restart drops the walk before this byte is used
      di = restart ? '0 : desc_index_ff;
      ul = restart ? '0 : units_left_ff;
      bp = restart ? '0 : byte_pos_ff;
      bt = restart ? '0 : byte_total_ff;
      pass = 1'b0;

      f_cur   = find_from({1'b0, di}, has_units);
      f_first = find_from('0, has_units);

      if (ul == '0) begin
         bp = '0;
         if (!f_cur.found) begin
            bt    = '0;
            f_cur = f_first;
         end
         if (!f_cur.found) begin
            pass = 1'b1;
            di   = '0;
         end else begin
            di = f_cur.idx;
            ul = cfg.unit_desc[f_cur.idx][CODE_W +: UNIT_W];
         end
      end

      push_bytes     = unit_buffer_ff;
      push_bytes[bp] = in_byte;
      have           = HAVE_W'(bp) + 1'b1;
      push_have      = have;
      push_meta      = '0;
      push           = 1'b0;

      desc_index_in = di;
      units_left_in = ul;
      byte_pos_in   = '0;
      byte_total_in = bt;

      sum        = {1'b0, bt} + (TOTAL_W+1)'(have);
      next_start = {1'b0, di} + 1'b1;
      f_next     = find_from(next_start, has_units);

      if (pass) begin
         // No descriptor has units: forward the byte on its own
         push = accept;
      end else if (have < unit_size(cfg, di)) begin
         byte_pos_in = have[POS_W-1:0];
      end else begin
         push          = accept;
         byte_total_in = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
         units_left_in = ul - 1'b1;
         if (units_left_in == '0) begin
            desc_index_in = next_start[DIDX_W-1:0];
            if (!f_next.found) begin
               push_meta.done  = 1'b1;
               push_meta.total = byte_total_in;
               desc_index_in   = '0;
               byte_total_in   = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         desc_index_ff <= '0;
         units_left_ff <= '0;
         byte_pos_ff   <= '0;
         byte_total_ff <= '0;
      end else if (accept) begin
         desc_index_ff <= desc_index_in;
         units_left_ff <= units_left_in;
         byte_pos_ff   <= byte_pos_in;
         byte_total_ff <= byte_total_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         unit_buffer_ff <= push_bytes;
      end
   end

   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      int'(byte_pos_ff) < MAX_UNIT_BYTES)
      else $error("gather position beyond unit buffer");

   a_loaded_index: assert property (@(posedge clock) disable iff (reset)
      (units_left_ff != '0) |-> (int'(desc_index_ff) < NUM_DESC_REGS))
      else $error("active descriptor index out of range");

endmodule

// File: sv/dbos_back.sv
// Back end: emits each queued unit's bytes in reverse order, one per cycle unless stalled.
// Depends on dbos_pkg.
`timescale 1ns / 1ps

module dbos_back
   import dbos_pkg::*;
#(
   parameter int MAX_UNIT_BYTES = 8
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   head_valid,
   input  logic [MAX_UNIT_BYTES-1:0][BYTE_W-1:0]  head_bytes,
   input  logic [$clog2(MAX_UNIT_BYTES+1)-1:0]    head_have,
   input  unit_meta_type                          head_meta,
   output logic                                   pop,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [BYTE_W-1:0]                      rsp_out_byte,
   output logic                                   rsp_burst_last,
   output logic                                   rsp_record_end,
   output logic [TOTAL_W-1:0]                     rsp_record_bytes
);

   localparam int HAVE_W = $clog2(MAX_UNIT_BYTES + 1);
   localparam int POS_W  = $clog2(MAX_UNIT_BYTES);

   logic [HAVE_W-1:0]  sent_ff, sent_in;
   logic               valid_ff, valid_in;
   logic [BYTE_W-1:0]  byte_ff, byte_in;
   logic               last_ff, last_in;
   logic               end_ff, end_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic               load;
   logic [HAVE_W-1:0]  rd_idx;

   assign load   = head_valid && (!valid_ff || !rsp_stall);
   assign rd_idx = head_have - 1'b1 - sent_ff;

   always_comb begin
      sent_in  = sent_ff;
      valid_in = valid_ff && rsp_stall;
      byte_in  = byte_ff;
      last_in  = last_ff;
      end_in   = end_ff;
      total_in = total_ff;
      pop      = 1'b0;
      if (load) begin
         valid_in = 1'b1;
         byte_in  = head_bytes[rd_idx[POS_W-1:0]];
         last_in  = (rd_idx == '0);
         end_in   = last_in && head_meta.done;
         total_in = end_in ? head_meta.total : '0;
         if (last_in) begin
            pop     = 1'b1;
            sent_in = '0;
         end else begin
            sent_in = sent_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sent_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         sent_ff  <= sent_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff  <= byte_in;
      last_ff  <= last_in;
      end_ff   <= end_in;
      total_ff <= total_in;
   end

   assign rsp_valid        = valid_ff;
   assign rsp_out_byte     = byte_ff;
   assign rsp_burst_last   = last_ff;
   assign rsp_record_end   = end_ff;
   assign rsp_record_bytes = total_ff;

   a_end_on_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_record_end) |-> rsp_burst_last)
      else $error("record end flagged inside a unit");

   a_sent_bound: assert property (@(posedge clock) disable iff (reset)
      (sent_ff != '0) |-> (head_valid && (sent_ff < head_have)))
      else $error("unit emit position lost its unit");

endmodule

// File: sv/descriptor_byte_order_swapper_top.sv
// Flow: a request byte that ends a unit is queued; the back end registers its first
//   byte on the result channel; the rest follow one per cycle while rsp_stall is low.
//   Bytes inside a unit give none. Throughput: one request and one result per cycle;
//   results wait on rsp_stall, requests stall only when the two-entry queue is full.
// Reset: synchronous, active high; clears registers, descriptor walk, queue, output.
// Depends on dbos_pkg, dbos_front, dbos_fifo and dbos_back.
`timescale 1ns / 1ps

module descriptor_byte_order_swapper_top
   import dbos_pkg::*;
#(
   parameter int MAX_DESCRIPTORS = 6,
   parameter int MAX_UNIT_BYTES  = 8,
   parameter int COUNT_BITS      = 14
) (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [BYTE_W-1:0]  req_in_byte,
   input  logic               req_restart,
   // result channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [BYTE_W-1:0]  rsp_out_byte,
   output logic               rsp_burst_last,
   output logic               rsp_record_end,
   output logic [TOTAL_W-1:0] rsp_record_bytes,
   // register port
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [ADDR_W-1:0]  paddr,
   input  logic [DATA_W-1:0]  pwdata,
   output logic [DATA_W-1:0]  prdata,
   output logic               pready
);

   localparam int HAVE_W      = $clog2(MAX_UNIT_BYTES + 1);
   localparam int BYTES_W     = MAX_UNIT_BYTES * BYTE_W;
   localparam int META_W      = $bits(unit_meta_type);
   localparam int ENTRY_W     = BYTES_W + HAVE_W + META_W;
   localparam int QUEUE_DEPTH = 2;

   cfg_type                               cfg_ff, cfg_in;
   reg_index_type                         reg_idx;
   logic                                  csr_write;
   logic                                  req_accept;
   logic                                  q_full;
   logic                                  q_push;
   logic                                  q_pop;
   logic                                  q_head_valid;
   logic [ENTRY_W-1:0]                    q_head;
   logic [MAX_UNIT_BYTES-1:0][BYTE_W-1:0] push_bytes;
   logic [HAVE_W-1:0]                     push_have;
   unit_meta_type                         push_meta;
   logic [MAX_UNIT_BYTES-1:0][BYTE_W-1:0] head_bytes;
   logic [HAVE_W-1:0]                     head_have;
   unit_meta_type                         head_meta;

   // ---------------------------------------------------------------------
   // Register port: pready tied high, words at 4-byte spacing
   // ---------------------------------------------------------------------
   assign pready    = 1'b1;
   assign reg_idx   = reg_index_type'(paddr[ADDR_W-1:2]);
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (reg_idx)
            REG_DESC_COUNT:  cfg_in.descriptor_count = pwdata[DCOUNT_W-1:0];
            REG_UNIT_DESC_0: cfg_in.unit_desc[0]     = pwdata[DESC_W-1:0];
            REG_UNIT_DESC_1: cfg_in.unit_desc[1]     = pwdata[DESC_W-1:0];
            REG_UNIT_DESC_2: cfg_in.unit_desc[2]     = pwdata[DESC_W-1:0];
            REG_UNIT_DESC_3: cfg_in.unit_desc[3]     = pwdata[DESC_W-1:0];
            REG_UNIT_DESC_4: cfg_in.unit_desc[4]     = pwdata[DESC_W-1:0];
            REG_UNIT_DESC_5: cfg_in.unit_desc[5]     = pwdata[DESC_W-1:0];
            default:         cfg_in = cfg_ff;  // drop writes past the map
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Readback of the stored registers; holes read as zero
   always_comb begin
      unique case (reg_idx)
         REG_DESC_COUNT:  prdata = DATA_W'(cfg_ff.descriptor_count);
         REG_UNIT_DESC_0: prdata = DATA_W'(cfg_ff.unit_desc[0]);
         REG_UNIT_DESC_1: prdata = DATA_W'(cfg_ff.unit_desc[1]);
         REG_UNIT_DESC_2: prdata = DATA_W'(cfg_ff.unit_desc[2]);
         REG_UNIT_DESC_3: prdata = DATA_W'(cfg_ff.unit_desc[3]);
         REG_UNIT_DESC_4: prdata = DATA_W'(cfg_ff.unit_desc[4]);
         REG_UNIT_DESC_5: prdata = DATA_W'(cfg_ff.unit_desc[5]);
         default:         prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------
   // Front end: hold requests only while the unit queue is full
   // ---------------------------------------------------------------------
   assign req_stall  = q_full;
   assign req_accept = req_valid && !req_stall;

   dbos_front #(
      .MAX_DESCRIPTORS (MAX_DESCRIPTORS),
      .MAX_UNIT_BYTES  (MAX_UNIT_BYTES),
      .COUNT_BITS      (COUNT_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .accept     (req_accept),
      .in_byte    (req_in_byte),
      .restart    (req_restart),
      .push       (q_push),
      .push_bytes (push_bytes),
      .push_have  (push_have),
      .push_meta  (push_meta)
   );

   // ---------------------------------------------------------------------
   // Unit queue: one entry per completed unit or forwarded byte
   // ---------------------------------------------------------------------
   dbos_fifo #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_data  ({push_bytes, push_have, push_meta}),
      .pop        (q_pop),
      .full       (q_full),
      .head_valid (q_head_valid),
      .head_data  (q_head)
   );

   assign head_bytes = q_head[ENTRY_W-1 -: BYTES_W];
   assign head_have  = q_head[META_W +: HAVE_W];
   assign head_meta  = unit_meta_type'(q_head[META_W-1:0]);

   // ---------------------------------------------------------------------
   // Back end: reverse each unit onto the result channel
   // ---------------------------------------------------------------------
   dbos_back #(
      .MAX_UNIT_BYTES (MAX_UNIT_BYTES)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .head_valid       (q_head_valid),
      .head_bytes       (head_bytes),
      .head_have        (head_have),
      .head_meta        (head_meta),
      .pop              (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_burst_last   (rsp_burst_last),
      .rsp_record_end   (rsp_record_end),
      .rsp_record_bytes (rsp_record_bytes)
   );

   a_stall_when_full: assert property (@(posedge clock) disable iff (reset)
      q_full |-> !req_accept)
      else $error("request taken while unit queue full");

   a_pop_feeds_output: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> (rsp_valid && rsp_burst_last))
      else $error("unit retired without its last byte on the output");

endmodule

// File: verif/descriptor_byte_order_swapper_top_test.sv
// Self-checking testbench for descriptor_byte_order_swapper_top: a directed and random
// byte stream under several descriptor lists, checked against a built-in walk predictor.
// Depends on dbos_pkg and the block's RTL.
`timescale 1ns / 1ps

module descriptor_byte_order_swapper_top_test
   import dbos_pkg::*;
();

   // One emitted byte as it should appear on the result channel
   typedef struct {
      logic [BYTE_W-1:0]  out_byte;
      logic               burst_last;
      logic               record_end;
      logic [TOTAL_W-1:0] record_bytes;
   } swapped_byte_type;

   // Tracks the descriptor walk and holds the bytes the block still owes us.
   class swap_scoreboard_type;
      logic [DCOUNT_W-1:0] desc_count;
      logic [DESC_W-1:0]   unit_desc [NUM_DESC_REGS];
      int unsigned         walk_index;
      int unsigned         units_left;
      int unsigned         byte_pos;
      int unsigned         running_total;
      logic [BYTE_W-1:0]   unit_bytes [8];
      swapped_byte_type    bytes_due [$];
      int                  errors;
      int                  requests;
      int                  results;
      int                  records;

      function new();
         desc_count = '0;
         foreach (unit_desc[i]) unit_desc[i] = '0;
         foreach (unit_bytes[i]) unit_bytes[i] = '0;
         walk_index    = 0;
         units_left    = 0;
         byte_pos      = 0;
         running_total = 0;
         errors        = 0;
         requests      = 0;
         results       = 0;
         records       = 0;
      endfunction

      function void set_register(reg_index_type idx, logic [DATA_W-1:0] value);
         if (idx == REG_DESC_COUNT) begin
            desc_count = value[DCOUNT_W-1:0];
         end else begin
            unit_desc[int'(idx) - 1] = value[DESC_W-1:0];
         end
      endfunction

      function int unsigned pending();
         return bytes_due.size();
      endfunction

      // A count above the number of registers is clipped to it
      function int unsigned active_count();
         return (desc_count > NUM_DESC_REGS) ? NUM_DESC_REGS : desc_count;
      endfunction

      function int unsigned unit_count(int unsigned i);
         if (i >= NUM_DESC_REGS) return 0;
         return unit_desc[i][DESC_W-1:CODE_W];
      endfunction

      function int unsigned unit_size(int unsigned i);
         if (i >= NUM_DESC_REGS) return 1;
         return 1 << unit_desc[i][CODE_W-1:0];
      endfunction

      // First descriptor at or after start that has units, else the active count
      function int unsigned next_loaded(int unsigned start);
         for (int unsigned i = start; i < active_count(); i++) begin
            if (unit_count(i) != 0) return i;
         end
         return active_count();
      endfunction

      function void push_byte(logic [BYTE_W-1:0] b, logic bl, logic re,
                              logic [TOTAL_W-1:0] rb);
         swapped_byte_type e;
         e.out_byte     = b;
         e.burst_last   = bl;
         e.record_end   = re;
         e.record_bytes = rb;
         bytes_due.push_back(e);
      endfunction

      function void note_request(logic [BYTE_W-1:0] b, logic rs);
         int unsigned f;
         int unsigned have;
         bit          done;
         requests++;
         if (rs) begin
            walk_index    = 0;
            units_left    = 0;
            byte_pos      = 0;
            running_total = 0;
         end
         if (units_left == 0) begin
            f = next_loaded(walk_index);
            if (f >= active_count()) begin
               // nothing left ahead of us: start over without closing a record
               running_total = 0;
               f = next_loaded(0);
            end
            byte_pos = 0;
            if (f >= active_count()) begin
               walk_index = 0;
               push_byte(b, 1'b1, 1'b0, '0);
               return;
            end
            walk_index = f;
            units_left = unit_count(f);
         end
         unit_bytes[byte_pos & 7] = b;
         have = (byte_pos & 7) + 1;
         // size is read fresh each byte, so a shrink mid-unit closes the unit early
         if (have < unit_size(walk_index)) begin
            byte_pos = have;
            return;
         end
         byte_pos = 0;
         running_total += have;
         if (running_total > TOTAL_MAX) running_total = TOTAL_MAX;
         units_left--;
         done = 1'b0;
         if (units_left == 0) begin
            walk_index++;
            if (next_loaded(walk_index) >= active_count()) done = 1'b1;
         end
         for (int unsigned k = 0; k < have; k++) begin
            push_byte(unit_bytes[(have - 1 - k) & 7], k + 1 == have,
                      done && (k + 1 == have),
                      (done && (k + 1 == have)) ? TOTAL_W'(running_total) : '0);
         end
         if (done) begin
            records++;
            walk_index    = 0;
            units_left    = 0;
            running_total = 0;
         end
      endfunction

      function void check_output(logic [BYTE_W-1:0] ob, logic bl, logic re,
                                 logic [TOTAL_W-1:0] rb);
         swapped_byte_type e;
         results++;
         if (bytes_due.size() == 0) begin
            $display("%0t: unexpected result byte %02h last %b end %b total %0d",
                     $time, ob, bl, re, rb);
            errors++;
            return;
         end
         e = bytes_due.pop_front();
         if (ob !== e.out_byte) begin
            $display("%0t: out_byte expected %02h actual %02h", $time, e.out_byte, ob);
            errors++;
         end
         if (bl !== e.burst_last) begin
            $display("%0t: burst_last expected %b actual %b", $time, e.burst_last, bl);
            errors++;
         end
         if (re !== e.record_end) begin
            $display("%0t: record_end expected %b actual %b", $time, e.record_end, re);
            errors++;
         end
         if (rb !== e.record_bytes) begin
            $display("%0t: record_bytes expected %0d actual %0d", $time,
                     e.record_bytes, rb);
            errors++;
         end
      endfunction
   endclass

   logic               clock;
   logic               reset         = 1'b1;
   logic               req_valid     = 1'b0;
   logic               req_stall;
   logic [BYTE_W-1:0]  req_in_byte   = '0;
   logic               req_restart   = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall     = 1'b0;
   logic [BYTE_W-1:0]  rsp_out_byte;
   logic               rsp_burst_last;
   logic               rsp_record_end;
   logic [TOTAL_W-1:0] rsp_record_bytes;
   logic               psel          = 1'b0;
   logic               penable       = 1'b0;
   logic               pwrite        = 1'b0;
   logic [ADDR_W-1:0]  paddr         = '0;
   logic [DATA_W-1:0]  pwdata        = '0;
   logic [DATA_W-1:0]  prdata;
   logic               pready;

   swap_scoreboard_type sb;
   int                  send_idle_pct = 0;
   int                  recv_idle_pct = 0;
   int                  csr_writes    = 0;

   descriptor_byte_order_swapper_top u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_in_byte      (req_in_byte),
      .req_restart      (req_restart),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_burst_last   (rsp_burst_last),
      .rsp_record_end   (rsp_record_end),
      .rsp_record_bytes (rsp_record_bytes),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop in case the block hangs or drops results
   initial begin
      #1_000_000;
      $display("descriptor_byte_order_swapper_top_test: errors");
      $finish;
   end

   // Receiver: pick the stall for the coming edge on the falling edge,
   // so it is settled well before the block samples it.
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
   end

   // Check every result the block hands over, in order of arrival
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_output(rsp_out_byte, rsp_burst_last, rsp_record_end, rsp_record_bytes);
      end
   end

   // Offer one request, idling first at random, and hold it until the block takes it.
   // Valid is only touched once per falling edge, so back-to-back requests keep it high.
   task automatic send_request(input logic [BYTE_W-1:0] b, input logic rs);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= b;
      req_restart <= rs;
      do @(posedge clock); while (!(req_valid && !req_stall));
      sb.note_request(b, rs);
   endtask

   // Two-phase register write: setup, then access until pready
   task automatic write_reg(input reg_index_type idx, input logic [DATA_W-1:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= ADDR_W'(int'(idx) * 4);
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      sb.set_register(idx, value);
      csr_writes++;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // Stop offering requests, wait for every owed byte, then give a gathered-only
   // byte time to settle inside the block before any register changes.
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   // Load a fresh descriptor list and stream random bytes through it.
   // list_kind 1 overfills descriptor_count; list_kind 2 sets every unit descriptor to all ones.
   task automatic run_random_phase(input int items, input int list_kind);
      int unsigned       code;
      int unsigned       cnt;
      logic [DESC_W-1:0] desc;
      drain_results();
      write_reg(REG_DESC_COUNT, (list_kind == 1) ? 7 : $urandom_range(0, 7));
      for (int i = 0; i < NUM_DESC_REGS; i++) begin
         code = $urandom_range(0, 3);
         // mostly short lists so records close often; now and then a huge count
         cnt  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 16383)
                                            : $urandom_range(0, 3);
         desc = (list_kind == 2) ? '1 : {cnt[UNITS_FIELD_W-1:0], code[CODE_W-1:0]};
         write_reg(reg_index_type'(int'(REG_UNIT_DESC_0) + i), desc);
      end
      repeat (items) begin
         send_request(BYTE_W'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
      end
   endtask

   initial begin
      int wait_cycles;
      sb = new();

      // Hold reset, then release it on a falling edge
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 34;
      recv_idle_pct = 45;

      // Empty list after reset: every byte passes straight through
      send_request(8'h00, 1'b0);
      send_request(8'hFF, 1'b1);

      // Two-byte unit, a skipped empty descriptor, then a four-byte unit that ends the record
      drain_results();
      write_reg(REG_DESC_COUNT, 3);
      write_reg(REG_UNIT_DESC_0, {14'd1, 2'd1});
      write_reg(REG_UNIT_DESC_1, '0);
      write_reg(REG_UNIT_DESC_2, {14'd1, 2'd2});
      send_request(8'h55, 1'b0);
      send_request(8'hAA, 1'b0);
      send_request(8'h00, 1'b0);
      send_request(8'hFF, 1'b0);
      send_request(8'h12, 1'b0);
      send_request(8'h34, 1'b0);

      // Restart in the middle of a unit: the restart byte opens a new unit
      send_request(8'h11, 1'b0);
      send_request(8'h22, 1'b1);
      send_request(8'h33, 1'b0);

      // Shrink the list mid-record so the walk starts over, then shrink the
      // unit size while bytes are gathered so the unit closes early
      drain_results();
      write_reg(REG_DESC_COUNT, 1);
      write_reg(REG_UNIT_DESC_0, {14'd1, 2'd3});
      send_request(8'h01, 1'b0);
      send_request(8'h02, 1'b0);
      send_request(8'h03, 1'b0);
      send_request(8'h04, 1'b0);
      drain_results();
      write_reg(REG_UNIT_DESC_0, {14'd1, 2'd2});
      send_request(8'h05, 1'b0);

      // Random part under three idling mixes; the walk carries over list changes
      for (int mode = 0; mode < 3; mode++) begin
         send_idle_pct = (mode == 0) ? 34 : (mode == 1) ? 45 : 0;
         recv_idle_pct = (mode == 0) ? 45 : (mode == 1) ? 34 : 0;
         for (int p = 0; p < 3; p++) begin
            run_random_phase(23, (mode == 0 && p == 0) ? 1 : (mode == 1 && p == 2) ? 2 : 0);
         end
      end

      // Let the tail drain, with a bound, then settle
      @(negedge clock);
      req_valid <= 1'b0;
      for (wait_cycles = 0; wait_cycles < 5000 && sb.pending() != 0; wait_cycles++) begin
         @(posedge clock);
      end
      repeat (20) @(posedge clock);
      if (sb.pending() != 0) begin
         $display("%0t: %0d expected result bytes never arrived", $time, sb.pending());
         sb.errors++;
      end

      $display("Streamed %0d request bytes and checked %0d swapped bytes, %0d records closed,",
               sb.requests, sb.results, sb.records);
      $display("across %0d register writes and three idling mixes; %0d mismatches.",
               csr_writes, sb.errors);
      if (sb.errors == 0) begin
         $display("descriptor_byte_order_swapper_top_test: clean");
      end else begin
         $display("descriptor_byte_order_swapper_top_test: errors");
      end
      $finish;
   end

endmodule

// File: descriptor_byte_order_swapper_top.f
sv/dbos_pkg.sv
sv/dbos_fifo.sv
sv/dbos_front.sv
sv/dbos_back.sv
sv/descriptor_byte_order_swapper_top.sv
verif/descriptor_byte_order_swapper_top_test.sv
